// File: rtl/core/wst_pkg.sv
// Shared widths, reset values and codes for the waypoint segment timer.
// Used by wst_divider and waypoint_segment_timer_core; depends on nothing.
package wst_pkg;

  // Field formats
  localparam int POS_W      = 24;   // signed Q5.18 radians
  localparam int DELTA_W    = POS_W + 1;
  localparam int SPEED_W    = 16;   // unsigned Q4.12 rad/s
  localparam int SEG_W      = 32;   // unsigned Q16.16 s
  localparam int ELAPSED_W  = 48;   // unsigned Q32.16 s
  localparam int FRAC_SHIFT = 10;   // Q5.18 / Q4.12 -> Q16.16
  localparam int DIVIDEND_W = POS_W + FRAC_SHIFT;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

  // Joint count
  localparam int MAX_JOINTS     = 7;
  localparam int NUM_JOINTS_DEF = 7;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SEGMENT_TIME = CFG_IDX_W'(MAX_JOINTS);

  // Reset values
  localparam logic [SPEED_W-1:0] SPEED_RESET   = SPEED_W'(4096);
  localparam logic [SEG_W-1:0]   MIN_SEG_RESET = SEG_W'(655);

  // Saturation limits
  localparam logic [SEG_W-1:0]     SEG_MAX     = '1;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  // Request operation codes
  typedef enum logic [0:0] {
    OP_START = 1'b0,
    OP_NEXT  = 1'b1
  } op_t;

  // Divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// File: rtl/core/wst_divider.sv
// Restoring divider, one quotient bit per cycle, for joint durations.
// Depends on wst_pkg for operand widths and the status struct.
module wst_divider (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [wst_pkg::DIVIDEND_W-1:0] dividend,
  input  logic [wst_pkg::SPEED_W-1:0]    divisor,
  output wst_pkg::div_status_t           status,
  output logic [wst_pkg::DIVIDEND_W-1:0] quotient
);
  import wst_pkg::*;

  localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIVIDEND_W - 1);

  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [SPEED_W-1:0]    rem_r, rem_nxt;
  logic [SPEED_W-1:0]    div_r;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [SPEED_W:0]      trial;
  logic [SPEED_W:0]      trial_diff;
  logic                  fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  // A zero divisor always fits, so the quotient comes out all ones.
  assign trial      = {rem_r, quo_r[DIVIDEND_W-1]};
  assign trial_diff = trial - {1'b0, div_r};
  assign fits       = (trial >= {1'b0, div_r});

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIVIDEND_W-2:0], fits};
      rem_nxt = fits ? trial_diff[SPEED_W-1:0] : trial[SPEED_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Hold control under reset; operands need none
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      div_r <= divisor;
    end
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign quotient    = quo_r;

endmodule

// File: rtl/core/waypoint_segment_timer_core.sv
// Waypoint segment timer: top level with sequencer, state and config registers.
// Depends on wst_pkg and wst_divider.
//
// Usage: requests arrive on the in_ channel (valid/ready), one seven-joint
// waypoint each, with in_op selecting start or next. Each request gives one
// result on the out_ channel (valid/ready): the segment time and the elapsed
// time since the last start. Speed limits and the least segment time are
// written over the cfg_ channel, index 0..6 for joint speeds, 7 for the
// least segment time; cfg_ready is always high.
// A start request shows its zero result in the cycle after acceptance.
// A next request works joint by joint: a load state forms the change and
// starts the shared 34-step restoring divider, a divide state waits for it,
// and after the last joint a final state applies the lower bound and the
// saturating elapsed add. One request is worked on at a time.
// Reset clears the stored waypoint and elapsed time, sets every speed limit
// to 1.0 rad/s and the least segment time to 655 (about 10 ms).
// When the receiver stalls, the result is held in the output register and
// in_ready stays low until that result is taken.
module waypoint_segment_timer_core #(
  parameter int NUM_JOINTS = wst_pkg::NUM_JOINTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wst_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wst_pkg::CFG_DATA_W-1:0]  cfg_data,
  // Waypoint requests
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_op,
  input  logic signed [wst_pkg::POS_W-1:0] in_joint0_position,
  input  logic signed [wst_pkg::POS_W-1:0] in_joint1_position,
  input  logic signed [wst_pkg::POS_W-1:0] in_joint2_position,
  input  logic signed [wst_pkg::POS_W-1:0] in_joint3_position,
  input  logic signed [wst_pkg::POS_W-1:0] in_joint4_position,
  input  logic signed [wst_pkg::POS_W-1:0] in_joint5_position,
  input  logic signed [wst_pkg::POS_W-1:0] in_joint6_position,
  // Results
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [wst_pkg::SEG_W-1:0]       out_segment_time,
  output logic [wst_pkg::ELAPSED_W-1:0]   out_elapsed_time
);
  import wst_pkg::*;

  localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
  localparam logic [JW-1:0] LAST_JOINT = JW'(NUM_JOINTS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_FINAL
  } state_t;

  state_t                  state_r, state_nxt;
  logic [JW-1:0]           jidx_r, jidx_nxt;
  logic [SEG_W-1:0]        seg_r, seg_nxt;
  logic [ELAPSED_W-1:0]    elapsed_r, elapsed_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [SEG_W-1:0]        out_seg_r, out_seg_nxt;
  logic [ELAPSED_W-1:0]    out_el_r, out_el_nxt;

  logic [SPEED_W-1:0]      speed_r [NUM_JOINTS];
  logic [SEG_W-1:0]        min_seg_r;
  logic signed [POS_W-1:0] prev_r [NUM_JOINTS];
  logic signed [POS_W-1:0] pos_r  [NUM_JOINTS];
  logic signed [POS_W-1:0] in_pos [MAX_JOINTS];

  logic                    in_fire;
  logic                    out_free;
  logic                    commit;
  logic signed [DELTA_W-1:0] delta;
  logic [DELTA_W-1:0]      mag;
  logic [DIVIDEND_W-1:0]   dividend;
  logic                    div_start;
  div_status_t             div_status;
  logic [DIVIDEND_W-1:0]   quotient;
  logic [SEG_W-1:0]        joint_time;
  logic [SEG_W-1:0]        seg_final;
  logic [ELAPSED_W:0]      elapsed_sum;

  assign in_pos[0] = in_joint0_position;
  assign in_pos[1] = in_joint1_position;
  assign in_pos[2] = in_joint2_position;
  assign in_pos[3] = in_joint3_position;
  assign in_pos[4] = in_joint4_position;
  assign in_pos[5] = in_joint5_position;
  assign in_pos[6] = in_joint6_position;

  // Handshakes: the output slot is free if empty or being drained
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && out_free;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign commit    = (state_r == ST_FINAL) && out_free;

  // Absolute change of the current joint, scaled to the Q16.16 quotient
  assign delta    = DELTA_W'(pos_r[jidx_r]) - DELTA_W'(prev_r[jidx_r]);
  assign mag      = delta[DELTA_W-1] ? DELTA_W'(-delta) : DELTA_W'(delta);
  assign dividend = {mag[POS_W-1:0], {FRAC_SHIFT{1'b0}}};
  assign div_start = (state_r == ST_LOAD);

  wst_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (speed_r[jidx_r]),
    .status   (div_status),
    .quotient (quotient)
  );

  // Saturate the joint duration to 32 bits
  assign joint_time = (|quotient[DIVIDEND_W-1:SEG_W]) ? SEG_MAX : quotient[SEG_W-1:0];

  // Apply the lower bound, then the saturating elapsed add
  assign seg_final   = (seg_r < min_seg_r) ? min_seg_r : seg_r;
  assign elapsed_sum = {1'b0, elapsed_r} + (ELAPSED_W + 1)'(seg_final);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    jidx_nxt      = jidx_r;
    seg_nxt       = seg_r;
    elapsed_nxt   = elapsed_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_seg_nxt   = out_seg_r;
    out_el_nxt    = out_el_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_op == OP_NEXT) begin
            jidx_nxt  = '0;
            seg_nxt   = '0;
            state_nxt = ST_LOAD;
          end else begin
            elapsed_nxt   = '0;
            out_seg_nxt   = '0;
            out_el_nxt    = '0;
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_LOAD: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_status.done) begin
          if (joint_time > seg_r) begin
            seg_nxt = joint_time;
          end
          if (jidx_r == LAST_JOINT) begin
            state_nxt = ST_FINAL;
          end else begin
            jidx_nxt  = jidx_r + 1'b1;
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_FINAL: begin
        if (out_free) begin
          elapsed_nxt   = elapsed_sum[ELAPSED_W] ? ELAPSED_MAX : elapsed_sum[ELAPSED_W-1:0];
          out_seg_nxt   = seg_final;
          out_el_nxt    = elapsed_sum[ELAPSED_W] ? ELAPSED_MAX : elapsed_sum[ELAPSED_W-1:0];
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      jidx_r      <= '0;
      seg_r       <= '0;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
      out_seg_r   <= '0;
      out_el_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      jidx_r      <= jidx_nxt;
      seg_r       <= seg_nxt;
      elapsed_r   <= elapsed_nxt;
      out_valid_r <= out_valid_nxt;
      out_seg_r   <= out_seg_nxt;
      out_el_r    <= out_el_nxt;
    end
  end

  // Waypoint storage: capture on request, advance previous on start or commit
  for (genvar j = 0; j < NUM_JOINTS; j++) begin : g_joint
    always_ff @(posedge clk) begin
      if (in_fire) begin
        pos_r[j] <= in_pos[j];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        prev_r[j] <= '0;
      end else if (in_fire && (in_op == OP_START)) begin
        prev_r[j] <= in_pos[j];
      end else if (commit) begin
        prev_r[j] <= pos_r[j];
      end
    end

    // Speed limit register; indexes of absent joints drop the write
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        speed_r[j] <= SPEED_RESET;
      end else if (cfg_valid && cfg_ready && (cfg_index == CFG_IDX_W'(j))) begin
        speed_r[j] <= cfg_data[SPEED_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_seg_r <= MIN_SEG_RESET;
    end else if (cfg_valid && cfg_ready && (cfg_index == REG_MIN_SEGMENT_TIME)) begin
      min_seg_r <= cfg_data[SEG_W-1:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_segment_time = out_seg_r;
  assign out_elapsed_time = out_el_r;

  // The divider only finishes while the sequencer waits for it
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_status.done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide state");

  // A new division never starts on a busy divider
  a_start_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) |-> !div_status.busy)
    else $error("divider started while busy");

  // Commit always lands a result and returns to idle
  a_commit_result: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> (out_valid_r && (state_r == ST_IDLE)))
    else $error("commit did not produce a result");

  // A result never drops below the least segment time on a next request
  a_seg_bound: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> (out_seg_r >= $past(min_seg_r)))
    else $error("segment time below the lower bound");

endmodule
